### hdl/che_pkg.sv
package che_pkg;

  // dividend width of the shared divider: covers the blend numerator magnitude
  localparam int unsigned DIV_W = 35;
  localparam int unsigned DVSR_W = 11;
  localparam int unsigned N_TABLES = 4;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned N_REGS = 7;

  typedef logic signed [15:0] entry_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_ADJUST = 1'b1
  } op_e;

  // register index, byte address is four times this
  typedef enum logic [2:0] {
    REG_GRAIN          = 3'd0,
    REG_WEIGHT_SCALE   = 3'd1,
    REG_ENTRY_LIMIT    = 3'd2,
    REG_PAWN_WEIGHT    = 3'd3,
    REG_NONPAWN_WEIGHT = 3'd4,
    REG_MINOR_WEIGHT   = 3'd5,
    REG_MATE_BOUND     = 3'd6
  } reg_e;

  // handshake between the sequencer and a multi-cycle unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

### hdl/correction_history_engine.sv
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_ready_o    op, side, four keys, depth, diff, raw eval
// result    out        out_valid_o / out_ready_i  adjusted_eval_o
// config    in         apb psel/penable/pwrite    seven registers at 4*i
//
// after reset a clearing pass writes zero to all 2*TABLE_ENTRIES rows of the
// four tables, with in_ready_o low
// one request at a time: key reduction, then the table read, then an update
// runs the shared bit-serial divider once per table and an adjust runs it once;
// an adjust result waits in the output register while the next request is taken
module correction_history_engine #(
  parameter int unsigned TABLE_ENTRIES = 16384
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         op_i,
  input  logic         side_i,
  input  logic [63:0]  pawn_key_i,
  input  logic [63:0]  white_key_i,
  input  logic [63:0]  black_key_i,
  input  logic [63:0]  minor_key_i,
  input  logic [7:0]   search_depth_i,
  input  logic signed [15:0] eval_diff_i,
  input  logic signed [15:0] raw_eval_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic signed [15:0] adjusted_eval_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import che_pkg::*;

  localparam int unsigned RW = $clog2(TABLE_ENTRIES);
  localparam int unsigned AW = $clog2(2 * TABLE_ENTRIES);
  localparam logic [AW:0] DEPTH = (AW+1)'(2 * TABLE_ENTRIES);

  localparam int unsigned T_PAWN  = 0;
  localparam int unsigned T_WHITE = 1;
  localparam int unsigned T_BLACK = 2;
  localparam int unsigned T_MINOR = 3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_RD, ST_RDW,
    ST_UMUL, ST_USTART, ST_UDIV,
    ST_AMUL, ST_ASTART, ST_ADIV, ST_AOUT
  } state_e;

  // configuration
  logic [10:0] grain_q, wscale_q;
  logic [14:0] limit_q, mate_q;
  logic [9:0]  pawn_w_q, npawn_w_q, minor_w_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_q   <= 11'd256;
      wscale_q  <= 11'd256;
      limit_q   <= 15'd16384;
      pawn_w_q  <= 10'd128;
      npawn_w_q <= 10'd128;
      minor_w_q <= 10'd128;
      mate_q    <= 15'd31744;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GRAIN:          grain_q   <= pwdata[10:0];
        REG_WEIGHT_SCALE:   wscale_q  <= pwdata[10:0];
        REG_ENTRY_LIMIT:    limit_q   <= pwdata[14:0];
        REG_PAWN_WEIGHT:    pawn_w_q  <= pwdata[9:0];
        REG_NONPAWN_WEIGHT: npawn_w_q <= pwdata[9:0];
        REG_MINOR_WEIGHT:   minor_w_q <= pwdata[9:0];
        REG_MATE_BOUND:     mate_q    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRAIN:          prdata = 32'(grain_q);
      REG_WEIGHT_SCALE:   prdata = 32'(wscale_q);
      REG_ENTRY_LIMIT:    prdata = 32'(limit_q);
      REG_PAWN_WEIGHT:    prdata = 32'(pawn_w_q);
      REG_NONPAWN_WEIGHT: prdata = 32'(npawn_w_q);
      REG_MINOR_WEIGHT:   prdata = 32'(minor_w_q);
      REG_MATE_BOUND:     prdata = 32'(mate_q);
      default:            prdata = '0;
    endcase
  end

  logic [10:0] g_eff, ws_eff;
  logic [14:0] mb_m1;
  assign g_eff  = (grain_q == '0) ? 11'd1 : grain_q;
  assign ws_eff = (wscale_q < 11'd17) ? 11'd17 : wscale_q;
  assign mb_m1  = (mate_q == '0) ? '0 : mate_q - 15'd1;

  // sequencer state and request registers
  state_e state_q;
  logic [AW:0] clr_q;
  logic [1:0] k_q;
  logic op_q, side_q;
  logic [4:0] w_q;
  logic signed [27:0] scaled_q;
  logic signed [15:0] raw_q;
  logic [N_TABLES-1:0][AW-1:0] addr_q;
  entry_t old_q [N_TABLES];
  logic signed [27:0] p1_q;
  logic signed [33:0] p2_q;
  logic signed [26:0] a0_q, a2_q;
  logic signed [27:0] a1_q;
  logic neg_q;
  logic out_valid_q;
  logic signed [15:0] out_q;

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // key reduction
  unit_ctl_t km_ctl;
  key_t [N_TABLES-1:0] keys;
  logic [N_TABLES-1:0][RW-1:0] rem;

  assign keys[T_PAWN]  = pawn_key_i;
  assign keys[T_WHITE] = white_key_i;
  assign keys[T_BLACK] = black_key_i;
  assign keys[T_MINOR] = minor_key_i;
  assign km_ctl.start  = in_acc;

  che_keymod #(.TE(TABLE_ENTRIES)) u_keymod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (km_ctl.start),
    .keys_i  (keys),
    .done_o  (km_ctl.done),
    .rem_o   (rem)
  );

  // shared divider
  unit_ctl_t dv_ctl;
  logic [DIV_W-1:0] dividend, quotient;
  logic [DVSR_W-1:0] divisor;

  logic signed [34:0] num;
  logic [DIV_W-1:0] num_mag;
  logic signed [29:0] asum;
  logic [29:0] asum_mag;

  assign num      = 35'(p1_q) + 35'(p2_q);
  assign num_mag  = num[34] ? DIV_W'(-num) : DIV_W'(num);
  assign asum     = 30'(a0_q) + 30'(a1_q) + 30'(a2_q);
  assign asum_mag = asum[29] ? 30'(-asum) : 30'(asum);

  assign dv_ctl.start = (state_q == ST_USTART) || (state_q == ST_ASTART);
  assign dividend     = (state_q == ST_USTART) ? num_mag : DIV_W'(asum_mag >> 7);
  assign divisor      = (state_q == ST_USTART) ? ws_eff : g_eff;

  che_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_ctl.start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (dv_ctl.done),
    .quotient_o (quotient)
  );

  // blend result, clamped to the entry limit
  logic signed [35:0] blend_v, lim_s;
  entry_t blend_e;
  assign blend_v = neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
  assign lim_s   = $signed(36'(limit_q));
  always_comb begin
    if (blend_v > lim_s) begin
      blend_e = entry_t'(lim_s);
    end else if (blend_v < -lim_s) begin
      blend_e = entry_t'(-lim_s);
    end else begin
      blend_e = entry_t'(blend_v);
    end
  end

  // adjusted eval, kept strictly inside the mate bound
  logic signed [36:0] adj_v, res_v, mb_s;
  logic signed [15:0] res_e;
  assign adj_v = neg_q ? -$signed({2'b0, quotient}) : $signed({2'b0, quotient});
  assign res_v = 37'(raw_q) + adj_v;
  assign mb_s  = $signed(37'(mb_m1));
  always_comb begin
    if (res_v > mb_s) begin
      res_e = 16'(mb_s);
    end else if (res_v < -mb_s) begin
      res_e = 16'(-mb_s);
    end else begin
      res_e = 16'(res_v);
    end
  end

  // tables
  logic [N_TABLES-1:0] we;
  logic [AW-1:0] waddr [N_TABLES];
  entry_t wdata;
  entry_t rdata [N_TABLES];
  logic re;

  assign re    = (state_q == ST_RD);
  assign wdata = (state_q == ST_CLEAR) ? entry_t'(0) : blend_e;

  for (genvar k = 0; k < N_TABLES; k++) begin : g_tab
    assign we[k] = (state_q == ST_CLEAR) ||
                   ((state_q == ST_UDIV) && dv_ctl.done && (k_q == 2'(k)));
    assign waddr[k] = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : addr_q[k];

    che_table #(.AW(AW)) u_table (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (waddr[k]),
      .wdata_i (wdata),
      .re_i    (re),
      .raddr_i (addr_q[k]),
      .rdata_o (rdata[k])
    );
  end

  logic [4:0] w_d;
  logic signed [27:0] scaled_d;
  logic [10:0] wsw;
  logic signed [16:0] nps;
  assign w_d      = (search_depth_i >= 8'd15) ? 5'd16 : 5'(search_depth_i + 8'd1);
  assign scaled_d = eval_diff_i * $signed({1'b0, g_eff});
  assign wsw      = ws_eff - 11'(w_q);
  assign nps      = 17'(old_q[T_WHITE]) + 17'(old_q[T_BLACK]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a result taken while the next one is ready is replaced in ST_AOUT
      if (out_valid_q && out_ready_i && (state_q != ST_AOUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == DEPTH - 1'b1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (km_ctl.done) begin
            state_q <= ST_RD;
          end
        end
        ST_RD:  state_q <= ST_RDW;
        ST_RDW: begin
          k_q     <= '0;
          state_q <= (op_q == OP_UPDATE) ? ST_UMUL : ST_AMUL;
        end
        ST_UMUL:   state_q <= ST_USTART;
        ST_USTART: state_q <= ST_UDIV;
        ST_UDIV: begin
          if (dv_ctl.done) begin
            k_q     <= k_q + 1'b1;
            state_q <= (k_q == 2'(N_TABLES - 1)) ? ST_IDLE : ST_UMUL;
          end
        end
        ST_AMUL:   state_q <= ST_ASTART;
        ST_ASTART: state_q <= ST_ADIV;
        ST_ADIV: begin
          if (dv_ctl.done) begin
            state_q <= ST_AOUT;
          end
        end
        ST_AOUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= res_e;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= op_i;
      side_q   <= side_i;
      w_q      <= w_d;
      scaled_q <= scaled_d;
      raw_q    <= raw_eval_i;
    end
    if (state_q == ST_MOD && km_ctl.done) begin
      for (int k = 0; k < N_TABLES; k++) begin
        addr_q[k] <= side_q ? AW'(TABLE_ENTRIES) + AW'(rem[k]) : AW'(rem[k]);
      end
    end
    if (state_q == ST_RDW) begin
      for (int k = 0; k < N_TABLES; k++) begin
        old_q[k] <= rdata[k];
      end
    end
    if (state_q == ST_UMUL) begin
      p1_q <= old_q[k_q] * $signed({1'b0, wsw});
      p2_q <= scaled_q * $signed({1'b0, w_q});
    end
    if (state_q == ST_USTART) begin
      neg_q <= num[34];
    end
    if (state_q == ST_AMUL) begin
      a0_q <= old_q[T_PAWN] * $signed({1'b0, pawn_w_q});
      a1_q <= nps * $signed({1'b0, npawn_w_q});
      a2_q <= old_q[T_MINOR] * $signed({1'b0, minor_w_q});
    end
    if (state_q == ST_ASTART) begin
      neg_q <= asum[29];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign adjusted_eval_o = out_q;

endmodule

### hdl/che_table.sv
module che_table #(
  parameter int unsigned AW = 15
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  che_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output che_pkg::entry_t       rdata_o
);
  import che_pkg::*;

  entry_t mem [2**AW];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/che_keymod.sv
module che_keymod #(
  parameter int unsigned TE = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  che_pkg::key_t [che_pkg::N_TABLES-1:0]  keys_i,
  output logic                                   done_o,
  output logic [che_pkg::N_TABLES-1:0][$clog2(TE)-1:0] rem_o
);
  import che_pkg::*;

  localparam int unsigned RW = $clog2(TE);
  localparam logic [RW:0] TE_W = (RW+1)'(TE);
  localparam int unsigned BITS = 8;
  localparam int unsigned STEPS = KEY_W / BITS;

  key_t [N_TABLES-1:0] key_q;
  logic [N_TABLES-1:0][RW-1:0] rem_q, rem_d;
  logic [$clog2(STEPS)-1:0] cnt_q;
  logic busy_q, done_q;

  // eight bits of each key per cycle, msb first, remainder kept below TE
  always_comb begin
    logic [RW-1:0] r;
    logic [RW:0] t;
    for (int k = 0; k < N_TABLES; k++) begin
      r = rem_q[k];
      for (int j = 0; j < BITS; j++) begin
        t = {r, key_q[k][KEY_W-1-j]};
        if (t >= TE_W) begin
          t = t - TE_W;
        end
        r = t[RW-1:0];
      end
      rem_d[k] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(STEPS))'(STEPS-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= keys_i;
      rem_q <= '0;
    end else if (busy_q) begin
      for (int k = 0; k < N_TABLES; k++) begin
        key_q[k] <= key_q[k] << BITS;
      end
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/che_div.sv
module che_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [che_pkg::DIV_W-1:0]     dividend_i,
  input  logic [che_pkg::DVSR_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [che_pkg::DIV_W-1:0]     quotient_o
);
  import che_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DVSR_W-1:0] rem_q, dvsr_q;
  logic [CW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [DVSR_W:0] trial;
  logic fits;

  // restoring, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import che_pkg::*;

  localparam int unsigned ENTRIES = 16384;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES = 3000;
  localparam int SEGMENT_ITEMS = 155;
  // first index past the register file
  localparam int unsigned REG_UNUSED = N_REGS;

  typedef enum int {TAB_PAWN = 0, TAB_WHITE, TAB_BLACK, TAB_MINOR} tab_e;

  typedef struct {
    op_e op;
    logic side;
    key_t key [4];
    logic [7:0] depth;
    logic signed [15:0] diff;
    logic signed [15:0] raw;
  } request_t;

  class correction_scoreboard;
    int unsigned cfg [8];
    entry_t tab [4][int];
    entry_t expected_evals [$];
    int mismatches;

    function new();
      cfg[REG_GRAIN] = 256;
      cfg[REG_WEIGHT_SCALE] = 256;
      cfg[REG_ENTRY_LIMIT] = 16384;
      cfg[REG_PAWN_WEIGHT] = 128;
      cfg[REG_NONPAWN_WEIGHT] = 128;
      cfg[REG_MINOR_WEIGHT] = 128;
      cfg[REG_MATE_BOUND] = 31744;
      mismatches = 0;
    endfunction

    function void write_reg(int idx, int unsigned v);
      case (idx)
        REG_GRAIN, REG_WEIGHT_SCALE: cfg[idx] = v & 32'h7FF;
        REG_ENTRY_LIMIT, REG_MATE_BOUND: cfg[idx] = v & 32'h7FFF;
        REG_PAWN_WEIGHT, REG_NONPAWN_WEIGHT, REG_MINOR_WEIGHT: cfg[idx] = v & 32'h3FF;
        default: ;
      endcase
    endfunction

    function entry_t read_entry(int t, int a);
      return tab[t].exists(a) ? tab[t][a] : entry_t'(0);
    endfunction

    function void note_request(request_t r);
      int a [4];
      longint g, ws, w, scaled, v, lim, adj, mb, res;
      for (int t = 0; t < 4; t++)
        a[t] = (r.side ? ENTRIES : 0) + int'(r.key[t] % ENTRIES);
      g = (cfg[REG_GRAIN] == 0) ? 1 : longint'(cfg[REG_GRAIN]);
      if (r.op == OP_UPDATE) begin
        w = (longint'(r.depth) + 1 < 16) ? longint'(r.depth) + 1 : 16;
        ws = (cfg[REG_WEIGHT_SCALE] < 17) ? 17 : longint'(cfg[REG_WEIGHT_SCALE]);
        lim = longint'(cfg[REG_ENTRY_LIMIT]);
        scaled = longint'(r.diff) * g;
        for (int t = 0; t < 4; t++) begin
          v = (longint'(read_entry(t, a[t])) * (ws - w) + scaled * w) / ws;
          if (v > lim) v = lim;
          if (v < -lim) v = -lim;
          tab[t][a[t]] = entry_t'(v);
        end
      end else begin
        adj = longint'(read_entry(TAB_PAWN, a[TAB_PAWN])) * longint'(cfg[REG_PAWN_WEIGHT])
            + (longint'(read_entry(TAB_WHITE, a[TAB_WHITE]))
               + longint'(read_entry(TAB_BLACK, a[TAB_BLACK])))
              * longint'(cfg[REG_NONPAWN_WEIGHT])
            + longint'(read_entry(TAB_MINOR, a[TAB_MINOR])) * longint'(cfg[REG_MINOR_WEIGHT]);
        adj = adj / 128;
        adj = adj / g;
        mb = (cfg[REG_MATE_BOUND] == 0) ? 1 : longint'(cfg[REG_MATE_BOUND]);
        res = longint'(r.raw) + adj;
        if (res > mb - 1) res = mb - 1;
        if (res < -(mb - 1)) res = -(mb - 1);
        expected_evals.push_back(entry_t'(res));
      end
    endfunction

    function void check_result(entry_t got);
      entry_t want;
      if (expected_evals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected adjusted_eval %0d", got);
        return;
      end
      want = expected_evals.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("adjusted_eval expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic side_i = 1'b0;
  logic [63:0] pawn_key_i = '0, white_key_i = '0, black_key_i = '0, minor_key_i = '0;
  logic [7:0] search_depth_i = '0;
  logic signed [15:0] eval_diff_i = '0, raw_eval_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] adjusted_eval_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  correction_history_engine dut (.*);

  correction_scoreboard sb = new();
  int tx_idle_pct = 15;
  int rx_idle_pct = 45;
  bit hold_req = 1'b0;
  longint cycles = 0;
  logic [13:0] low_pool [6] = '{14'd0, 14'd16383, 14'd1, 14'd8192, 14'd77, 14'd4095};

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(adjusted_eval_o);
      if (in_valid_i && in_ready_o) begin
        r.op = op_e'(op_i);
        r.side = side_i;
        r.key[TAB_PAWN] = pawn_key_i;
        r.key[TAB_WHITE] = white_key_i;
        r.key[TAB_BLACK] = black_key_i;
        r.key[TAB_MINOR] = minor_key_i;
        r.depth = search_depth_i;
        r.diff = eval_diff_i;
        r.raw = raw_eval_i;
        sb.note_request(r);
      end
    end
  end

  task automatic apb_write(int unsigned idx, int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int unsigned g, int unsigned ws, int unsigned lim, int unsigned pw,
                           int unsigned nw, int unsigned mw, int unsigned mb);
    apb_write(REG_GRAIN, g);
    apb_write(REG_WEIGHT_SCALE, ws);
    apb_write(REG_ENTRY_LIMIT, lim);
    apb_write(REG_PAWN_WEIGHT, pw);
    apb_write(REG_NONPAWN_WEIGHT, nw);
    apb_write(REG_MINOR_WEIGHT, mw);
    apb_write(REG_MATE_BOUND, mb);
  endtask

  // updates give no result, so wait out the block's own latency as well
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_evals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_request(request_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= r.op;
    side_i <= r.side;
    pawn_key_i <= r.key[TAB_PAWN];
    white_key_i <= r.key[TAB_WHITE];
    black_key_i <= r.key[TAB_BLACK];
    minor_key_i <= r.key[TAB_MINOR];
    search_depth_i <= r.depth;
    eval_diff_i <= r.diff;
    raw_eval_i <= r.raw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // keys mostly land on a few rows so updates and adjusts meet
  function automatic key_t pick_key();
    key_t k;
    k = {$urandom, $urandom};
    if ($urandom_range(9) < 8) k[13:0] = low_pool[$urandom_range(5)];
    return k;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op = op_e'($urandom_range(1));
    r.side = 1'($urandom_range(1));
    for (int t = 0; t < 4; t++) r.key[t] = pick_key();
    r.depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
    r.diff = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(int'($urandom_range(400)) - 200);
    r.raw = 16'($urandom);
    return r;
  endfunction

  function automatic request_t make_request(op_e op, logic side, key_t k, logic [7:0] depth,
                                            logic signed [15:0] diff, logic signed [15:0] raw);
    request_t r;
    r.op = op;
    r.side = side;
    for (int t = 0; t < 4; t++) r.key[t] = k;
    r.depth = depth;
    r.diff = diff;
    r.raw = raw;
    return r;
  endfunction

  task automatic random_segment(int n);
    for (int i = 0; i < n; i++) send_request(random_request());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass keeps in_ready_o low
    do @(posedge clk_i); while (!in_ready_o);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);

    // directed: field extremes, both ops and sides, saturation
    send_request(make_request(OP_ADJUST, 1'b0, '0, 8'd0, 16'sd0, 16'sd0));
    send_request(make_request(OP_UPDATE, 1'b0, '0, 8'd0, 16'sh7FFF, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b0, '0, 8'd0, 16'sd0, 16'sh7FFF));
    send_request(make_request(OP_UPDATE, 1'b1, '1, 8'd255, -16'sh8000, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b1, '1, 8'd0, 16'sd0, -16'sh8000));
    send_request(make_request(OP_UPDATE, 1'b1, '1, 8'd15, 16'sd300, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b1, '1, 8'd255, 16'sh7FFF, 16'sd100));
    send_request(make_request(OP_UPDATE, 1'b0, 64'hFFFF_FFFF_FFFF_C000, 8'd14, -16'sd5, 16'sh7FFF));
    send_request(make_request(OP_ADJUST, 1'b0, '0, 8'd0, 16'sd0, -16'sd1));
    send_request(make_request(OP_UPDATE, 1'b0, 64'h0000_0000_0000_3FFF, 8'd1, 16'sd1, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b0, 64'h8000_0000_0000_3FFF, 8'd0, 16'sd0, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b1, '0, 8'd0, 16'sd0, 16'sd0));
    drain();

    // zero grain, small weight scale, full-range weights
    configure(0, 0, 32767, 1023, 1023, 1023, 32767);
    send_request(make_request(OP_UPDATE, 1'b0, '0, 8'd255, 16'sh7FFF, 16'sd0));
    send_request(make_request(OP_ADJUST, 1'b0, '0, 8'd0, 16'sd0, 16'sh7FFF));
    send_request(make_request(OP_ADJUST, 1'b0, '0, 8'd0, 16'sd0, -16'sh8000));
    random_segment(SEGMENT_ITEMS);
    drain();

    configure(1024, 1024, 100, 0, 7, 300, 1);
    random_segment(SEGMENT_ITEMS);
    drain();

    tx_idle_pct = 45;
    rx_idle_pct = 15;
    // zero mate bound acts as one
    configure(2047, 2047, 32767, 1023, 0, 1023, 0);
    random_segment(60);
    drain();

    configure(1, 17, 20000, 200, 100, 50, 500);
    random_segment(SEGMENT_ITEMS);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(3, 16, 32767, 512, 256, 64, 31744);
    random_segment(SEGMENT_ITEMS);
    hold_req = 1'b1;
    random_segment(80);
    // pause until every adjust has come back
    in_valid_i <= 1'b0;
    while (sb.expected_evals.size() != 0) @(posedge clk_i);
    random_segment(80);
    drain();

    configure(1, 16, 0, 1023, 1023, 1023, 32767);
    random_segment(100);
    drain();

    if (sb.mismatches == 0 && sb.expected_evals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
